// File: rtl/srwc_pkg.sv
// ----------------------------------------------------------------------------
// srwc_pkg
// Shared types, codes and the control store of the selective-repeat window
// control block.
// ----------------------------------------------------------------------------
package srwc_pkg;

    // Field widths of the event and command beats
    localparam int ACTION_W     = 3;
    localparam int KIND_W       = 2;
    localparam int SEQ_FIELD_W  = 5;
    localparam int CMD_W        = 3;
    localparam int SLOT_FIELD_W = 4;

    // Defaults of the top-level parameters
    localparam int SEQ_MAX_DEF      = 31;
    localparam int WINDOW_SLOTS_DEF = 16;

    // Event actions
    localparam logic [ACTION_W-1:0] ACT_PACKET       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PHYS_READY   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FRAME        = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DATA_TIMEOUT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ACK_TIMEOUT  = 3'd4;

    // Received frame kinds
    localparam logic [KIND_W-1:0] FK_DATA = 2'd0;
    localparam logic [KIND_W-1:0] FK_ACK  = 2'd1;
    localparam logic [KIND_W-1:0] FK_NAK  = 2'd2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_SEND_DATA   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEND_ACK    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND_NAK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELIVER     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP_TIMER  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RESTART_ACK = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STATUS      = 3'd6;

    // Branch conditions: a true condition skips the step and jumps
    localparam int COND_N = 11;
    typedef logic [3:0] cond_t;
    localparam cond_t COND_NEVER          = 4'd0;
    localparam cond_t COND_FULL           = 4'd1;
    localparam cond_t COND_NOT_GOOD       = 4'd2;
    localparam cond_t COND_KIND_NOT_DATA  = 4'd3;
    localparam cond_t COND_NAK_DUE        = 4'd4;
    localparam cond_t COND_NO_STORE       = 4'd5;
    localparam cond_t COND_RB_EMPTY       = 4'd6;
    localparam cond_t COND_NONE_DELIVERED = 4'd7;
    localparam cond_t COND_NO_RESEND      = 4'd8;
    localparam cond_t COND_ACK_OUTSIDE    = 4'd9;
    localparam cond_t COND_NAK_BLOCKED    = 4'd10;

    // Sequence operand select
    typedef logic [2:0] sel_t;
    localparam sel_t SEL_NONE      = 3'd0;
    localparam sel_t SEL_NEXT      = 3'd1;
    localparam sel_t SEL_SEND_BASE = 3'd2;
    localparam sel_t SEL_RECV_BASE = 3'd3;
    localparam sel_t SEL_FRAME_SEQ = 3'd4;
    localparam sel_t SEL_WANT      = 3'd5;

    // Datapath operations
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE     = 3'd0;
    localparam op_t OP_NEW_DATA = 3'd1;
    localparam op_t OP_SET_PHYS = 3'd2;
    localparam op_t OP_MARK     = 3'd3;
    localparam op_t OP_DELIVER  = 3'd4;
    localparam op_t OP_RETIRE   = 3'd5;

    // Control store addresses
    typedef logic [3:0] upc_t;
    localparam upc_t UPC_PACKET   = 4'd0;
    localparam upc_t UPC_PHYS     = 4'd1;
    localparam upc_t UPC_DATA_TO  = 4'd2;
    localparam upc_t UPC_ACK_TO   = 4'd3;
    localparam upc_t UPC_FRAME    = 4'd4;
    localparam upc_t UPC_KIND     = 4'd5;
    localparam upc_t UPC_EXPECT   = 4'd6;
    localparam upc_t UPC_DATA_NAK = 4'd7;
    localparam upc_t UPC_STORE    = 4'd8;
    localparam upc_t UPC_DELIVER  = 4'd9;
    localparam upc_t UPC_DLV_END  = 4'd10;
    localparam upc_t UPC_NAK_CHK  = 4'd11;
    localparam upc_t UPC_RETIRE   = 4'd12;
    localparam upc_t UPC_BAD      = 4'd13;
    localparam upc_t UPC_STATUS   = 4'd14;

    typedef struct packed {
        cond_t             cond;
        upc_t              jmp;
        upc_t              nxt;
        logic              emit;
        logic [CMD_W-1:0]  cmd;
        sel_t              sel;
        op_t               op;
        logic              done;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic             start;
        logic             exec;
        logic             emit;
        logic [CMD_W-1:0] cmd;
        sel_t             sel;
        op_t              op;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic [COND_N-1:0] flags;
        logic              out_blocked;
    } dp_stat_t;

    function automatic ucode_t mk(cond_t cond, upc_t jmp, upc_t nxt, logic emit,
                                  logic [CMD_W-1:0] cmd, sel_t sel, op_t op,
                                  logic done);
        ucode_t w;
        w.cond = cond;
        w.jmp  = jmp;
        w.nxt  = nxt;
        w.emit = emit;
        w.cmd  = cmd;
        w.sel  = sel;
        w.op   = op;
        w.done = done;
        return w;
    endfunction

    function automatic ucode_t ucode_word(upc_t pc);
        ucode_t w;
        unique case (pc)
            UPC_PACKET:   w = mk(COND_FULL, UPC_STATUS, UPC_STATUS, 1'b1,
                                 CMD_SEND_DATA, SEL_NEXT, OP_NEW_DATA, 1'b0);
            UPC_PHYS:     w = mk(COND_NEVER, UPC_STATUS, UPC_STATUS, 1'b0,
                                 CMD_STATUS, SEL_NONE, OP_SET_PHYS, 1'b0);
            UPC_DATA_TO:  w = mk(COND_NEVER, UPC_STATUS, UPC_STATUS, 1'b1,
                                 CMD_SEND_DATA, SEL_SEND_BASE, OP_NONE, 1'b0);
            UPC_ACK_TO:   w = mk(COND_NEVER, UPC_STATUS, UPC_STATUS, 1'b1,
                                 CMD_SEND_ACK, SEL_NONE, OP_NONE, 1'b0);
            UPC_FRAME:    w = mk(COND_NOT_GOOD, UPC_BAD, UPC_KIND, 1'b0,
                                 CMD_STATUS, SEL_NONE, OP_NONE, 1'b0);
            UPC_KIND:     w = mk(COND_KIND_NOT_DATA, UPC_NAK_CHK, UPC_EXPECT, 1'b0,
                                 CMD_STATUS, SEL_NONE, OP_NONE, 1'b0);
            UPC_EXPECT:   w = mk(COND_NAK_DUE, UPC_DATA_NAK, UPC_STORE, 1'b1,
                                 CMD_RESTART_ACK, SEL_NONE, OP_NONE, 1'b0);
            UPC_DATA_NAK: w = mk(COND_NEVER, UPC_STORE, UPC_STORE, 1'b1,
                                 CMD_SEND_NAK, SEL_NONE, OP_NONE, 1'b0);
            UPC_STORE:    w = mk(COND_NO_STORE, UPC_NAK_CHK, UPC_DELIVER, 1'b0,
                                 CMD_STATUS, SEL_FRAME_SEQ, OP_MARK, 1'b0);
            UPC_DELIVER:  w = mk(COND_RB_EMPTY, UPC_DLV_END, UPC_DELIVER, 1'b1,
                                 CMD_DELIVER, SEL_RECV_BASE, OP_DELIVER, 1'b0);
            UPC_DLV_END:  w = mk(COND_NONE_DELIVERED, UPC_NAK_CHK, UPC_NAK_CHK, 1'b1,
                                 CMD_RESTART_ACK, SEL_NONE, OP_NONE, 1'b0);
            UPC_NAK_CHK:  w = mk(COND_NO_RESEND, UPC_RETIRE, UPC_RETIRE, 1'b1,
                                 CMD_SEND_DATA, SEL_WANT, OP_NONE, 1'b0);
            UPC_RETIRE:   w = mk(COND_ACK_OUTSIDE, UPC_STATUS, UPC_RETIRE, 1'b1,
                                 CMD_STOP_TIMER, SEL_SEND_BASE, OP_RETIRE, 1'b0);
            UPC_BAD:      w = mk(COND_NAK_BLOCKED, UPC_STATUS, UPC_STATUS, 1'b1,
                                 CMD_SEND_NAK, SEL_NONE, OP_NONE, 1'b0);
            default:      w = mk(COND_NEVER, UPC_STATUS, UPC_STATUS, 1'b1,
                                 CMD_STATUS, SEL_NONE, OP_NONE, 1'b1);
        endcase
        return w;
    endfunction

    function automatic upc_t entry_pc(logic [ACTION_W-1:0] action);
        upc_t pc;
        unique case (action)
            ACT_PACKET:       pc = UPC_PACKET;
            ACT_PHYS_READY:   pc = UPC_PHYS;
            ACT_FRAME:        pc = UPC_FRAME;
            ACT_DATA_TIMEOUT: pc = UPC_DATA_TO;
            ACT_ACK_TIMEOUT:  pc = UPC_ACK_TO;
            default:          pc = UPC_STATUS;
        endcase
        return pc;
    endfunction

endpackage

// File: rtl/srwc_if.sv
// ----------------------------------------------------------------------------
// srwc_if
// Event and command channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface srwc_evt_if import srwc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic                   frame_good;
    logic [KIND_W-1:0]      frame_kind;
    logic [SEQ_FIELD_W-1:0] frame_seq;
    logic [SEQ_FIELD_W-1:0] peer_ack;

    modport source (output valid, action, frame_good, frame_kind, frame_seq,
                    peer_ack, input ready);
    modport sink   (input valid, action, frame_good, frame_kind, frame_seq,
                    peer_ack, output ready);
endinterface

interface srwc_cmd_if import srwc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [SEQ_FIELD_W-1:0]  seq_out;
    logic [SEQ_FIELD_W-1:0]  ack_out;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    network_enable;
    logic                    last;

    modport source (output valid, command, seq_out, ack_out, slot,
                    network_enable, last, input ready);
    modport sink   (input valid, command, seq_out, ack_out, slot,
                    network_enable, last, output ready);
endinterface

// File: rtl/srwc_useq.sv
// ----------------------------------------------------------------------------
// srwc_useq
// Microcode sequencer: step counter, control store read and conditional
// branching on datapath flags.
// ----------------------------------------------------------------------------
module srwc_useq import srwc_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  dp_stat_t            stat,
    output ctrl_t               ctrl
);

    upc_t   pc_reg, pc_next;
    logic   busy_reg, busy_next;
    ucode_t word;
    logic   taken;
    logic   step_ok;

    assign word     = ucode_word(pc_reg);
    assign taken    = stat.flags[word.cond];
    assign in_ready = !busy_reg;

    // hold the step while its beat cannot enter the output register
    assign step_ok = busy_reg && !(word.emit && !taken && stat.out_blocked);

    always_comb
    begin
        ctrl.start = in_valid && in_ready;
        ctrl.exec  = step_ok && !taken;
        ctrl.emit  = word.emit;
        ctrl.cmd   = word.cmd;
        ctrl.sel   = word.sel;
        ctrl.op    = word.op;
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (ctrl.start)
        begin
            pc_next   = entry_pc(action);
            busy_next = 1'b1;
        end
        else if (step_ok)
        begin
            if (taken)
                pc_next = word.jmp;
            else if (word.done)
                busy_next = 1'b0;
            else
                pc_next = word.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= UPC_STATUS;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// File: rtl/srwc_datapath.sv
// ----------------------------------------------------------------------------
// srwc_datapath
// Window registers, arrival bitmap, branch flags and the command output
// register, driven one control word per cycle while cmd is not stalled.
// ----------------------------------------------------------------------------
module srwc_datapath import srwc_pkg::*; #(
    parameter int SEQ_MAX      = SEQ_MAX_DEF,
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_t                  ctrl,
    input  logic                   frame_good,
    input  logic [KIND_W-1:0]      frame_kind,
    input  logic [SEQ_FIELD_W-1:0] frame_seq,
    input  logic [SEQ_FIELD_W-1:0] peer_ack,
    output dp_stat_t               stat,
    srwc_cmd_if.source             cmd
);

    localparam int SEQ_MOD  = SEQ_MAX + 1;
    localparam int MOD_W    = $clog2(SEQ_MOD);
    localparam int CNT_W    = $clog2(WINDOW_SLOTS + 1);
    localparam int SEQ_W0   = (MOD_W > SEQ_FIELD_W) ? MOD_W : SEQ_FIELD_W;
    localparam int SEQ_W    = (SEQ_W0 > CNT_W) ? SEQ_W0 : CNT_W;
    localparam int SLOT_W   = $clog2(WINDOW_SLOTS);
    localparam int SPAN     = 2 ** SEQ_W;
    localparam int WRAP_MAX = 8;

    typedef logic [SEQ_W-1:0] seq_t;

    function automatic seq_t adv(seq_t k);
        return (k < SEQ_W'(SEQ_MAX)) ? seq_t'(k + 1'b1) : '0;
    endfunction

    function automatic logic in_win(seq_t lo, seq_t x, seq_t hi);
        return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
               ((x < hi) && (hi < lo));
    endfunction

    // window state
    seq_t                    send_base_reg, send_base_next;
    seq_t                    next_send_reg, next_send_next;
    seq_t                    recv_base_reg, recv_base_next;
    seq_t                    recv_limit_reg, recv_limit_next;
    logic [CNT_W-1:0]        buf_cnt_reg, buf_cnt_next;
    logic                    nak_ok_reg, nak_ok_next;
    logic                    phys_reg, phys_next;
    logic [WINDOW_SLOTS-1:0] arrived_reg, arrived_next;
    logic                    dlv_reg, dlv_next;

    // latched event
    logic                   good_reg;
    logic [KIND_W-1:0]      kind_reg;
    seq_t                   fseq_reg;
    seq_t                   fack_reg;
    seq_t                   want_reg;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [CMD_W-1:0]        out_cmd_reg;
    logic [SEQ_FIELD_W-1:0]  out_seq_reg;
    logic [SEQ_FIELD_W-1:0]  out_ack_reg;
    logic [SLOT_FIELD_W-1:0] out_slot_reg;
    logic                    out_ne_reg;

    logic [SLOT_W-1:0] slot_lut [SPAN];
    logic [SEQ_W:0]    want_calc;
    seq_t              cur_seq;
    logic [SLOT_W-1:0] cur_slot;
    seq_t              ack_val;
    logic              net_en;
    logic              is_send;
    logic [COND_N-1:0] flags;

    // constant table: sequence number to buffer slot
    for (genvar g = 0; g < SPAN; g++)
    begin : g_slot
        assign slot_lut[g] = SLOT_W'(g % WINDOW_SLOTS);
    end

    // NAK target: peer_ack + 1, folded into the sequence space
    always_comb
    begin
        want_calc = (SEQ_W + 1)'(peer_ack) + 1'b1;
        for (int i = 0; i < WRAP_MAX; i++)
        begin
            if (want_calc >= (SEQ_W + 1)'(SEQ_MOD))
                want_calc = want_calc - (SEQ_W + 1)'(SEQ_MOD);
        end
    end

    always_comb
    begin
        unique case (ctrl.sel)
            SEL_NEXT:      cur_seq = next_send_reg;
            SEL_SEND_BASE: cur_seq = send_base_reg;
            SEL_RECV_BASE: cur_seq = recv_base_reg;
            SEL_FRAME_SEQ: cur_seq = fseq_reg;
            SEL_WANT:      cur_seq = want_reg;
            default:       cur_seq = '0;
        endcase
    end

    assign cur_slot = slot_lut[cur_seq];
    assign ack_val  = (recv_base_reg == '0) ? SEQ_W'(SEQ_MAX) : seq_t'(recv_base_reg - 1'b1);
    assign net_en   = (buf_cnt_reg < CNT_W'(WINDOW_SLOTS)) && phys_reg;
    assign is_send  = (ctrl.cmd == CMD_SEND_DATA) || (ctrl.cmd == CMD_SEND_ACK) ||
                      (ctrl.cmd == CMD_SEND_NAK);

    always_comb
    begin
        flags                      = '0;
        flags[COND_NEVER]          = 1'b0;
        flags[COND_FULL]           = buf_cnt_reg >= CNT_W'(WINDOW_SLOTS);
        flags[COND_NOT_GOOD]       = !good_reg;
        flags[COND_KIND_NOT_DATA]  = kind_reg != FK_DATA;
        flags[COND_NAK_DUE]        = (fseq_reg != recv_base_reg) && nak_ok_reg;
        flags[COND_NO_STORE]       = !(in_win(recv_base_reg, fseq_reg, recv_limit_reg) &&
                                       !arrived_reg[cur_slot]);
        flags[COND_RB_EMPTY]       = !arrived_reg[cur_slot];
        flags[COND_NONE_DELIVERED] = !dlv_reg;
        flags[COND_NO_RESEND]      = (kind_reg != FK_NAK) ||
                                     !in_win(send_base_reg, want_reg, next_send_reg);
        flags[COND_ACK_OUTSIDE]    = !in_win(send_base_reg, fack_reg, next_send_reg);
        flags[COND_NAK_BLOCKED]    = !nak_ok_reg;
    end

    assign stat.flags       = flags;
    assign stat.out_blocked = out_valid_reg && !cmd.ready;

    always_comb
    begin
        send_base_next  = send_base_reg;
        next_send_next  = next_send_reg;
        recv_base_next  = recv_base_reg;
        recv_limit_next = recv_limit_reg;
        buf_cnt_next    = buf_cnt_reg;
        nak_ok_next     = nak_ok_reg;
        phys_next       = phys_reg;
        arrived_next    = arrived_reg;
        dlv_next        = dlv_reg;

        if (ctrl.start)
            dlv_next = 1'b0;

        if (ctrl.exec)
        begin
            // every frame send consumes the physical layer
            if (ctrl.emit && is_send)
                phys_next = 1'b0;
            if (ctrl.emit && (ctrl.cmd == CMD_SEND_NAK))
                nak_ok_next = 1'b0;

            unique case (ctrl.op)
                OP_NEW_DATA:
                begin
                    buf_cnt_next   = buf_cnt_reg + 1'b1;
                    next_send_next = adv(next_send_reg);
                end
                OP_SET_PHYS:
                    phys_next = 1'b1;
                OP_MARK:
                    arrived_next[cur_slot] = 1'b1;
                OP_DELIVER:
                begin
                    arrived_next[cur_slot] = 1'b0;
                    nak_ok_next     = 1'b1;
                    recv_base_next  = adv(recv_base_reg);
                    recv_limit_next = adv(recv_limit_reg);
                    dlv_next        = 1'b1;
                end
                OP_RETIRE:
                begin
                    if (buf_cnt_reg != '0)
                        buf_cnt_next = buf_cnt_reg - 1'b1;
                    send_base_next = adv(send_base_reg);
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.exec && ctrl.emit)
            out_valid_next = 1'b1;
        else if (cmd.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_base_reg  <= '0;
            next_send_reg  <= '0;
            recv_base_reg  <= '0;
            recv_limit_reg <= SEQ_W'(WINDOW_SLOTS);
            buf_cnt_reg    <= '0;
            nak_ok_reg     <= 1'b1;
            phys_reg       <= 1'b0;
            arrived_reg    <= '0;
            dlv_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            send_base_reg  <= send_base_next;
            next_send_reg  <= next_send_next;
            recv_base_reg  <= recv_base_next;
            recv_limit_reg <= recv_limit_next;
            buf_cnt_reg    <= buf_cnt_next;
            nak_ok_reg     <= nak_ok_next;
            phys_reg       <= phys_next;
            arrived_reg    <= arrived_next;
            dlv_reg        <= dlv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            good_reg <= frame_good;
            kind_reg <= frame_kind;
            fseq_reg <= SEQ_W'(frame_seq);
            fack_reg <= SEQ_W'(peer_ack);
            want_reg <= want_calc[SEQ_W-1:0];
        end
        if (ctrl.exec && ctrl.emit)
        begin
            out_cmd_reg  <= ctrl.cmd;
            out_seq_reg  <= (ctrl.cmd == CMD_SEND_DATA) ? SEQ_FIELD_W'(cur_seq) : '0;
            out_ack_reg  <= is_send ? SEQ_FIELD_W'(ack_val) : '0;
            out_slot_reg <= ((ctrl.cmd == CMD_SEND_DATA) || (ctrl.cmd == CMD_DELIVER) ||
                             (ctrl.cmd == CMD_STOP_TIMER)) ? SLOT_FIELD_W'(cur_slot) : '0;
            out_ne_reg   <= (ctrl.cmd == CMD_STATUS) ? net_en : 1'b0;
        end
    end

    assign cmd.valid          = out_valid_reg;
    assign cmd.command        = out_cmd_reg;
    assign cmd.seq_out        = out_seq_reg;
    assign cmd.ack_out        = out_ack_reg;
    assign cmd.slot           = out_slot_reg;
    assign cmd.network_enable = out_ne_reg;
    assign cmd.last           = (out_cmd_reg == CMD_STATUS);

endmodule

// File: rtl/selective_repeat_window_control.sv
// ----------------------------------------------------------------------------
// selective_repeat_window_control
// Control plane of a selective-repeat link: window bookkeeping and the
// command run for each link event.
// ----------------------------------------------------------------------------
// evt: one beat per event (packet ready, physical ready, frame received,
//   data timeout, ack timeout) with the received frame's check result,
//   kind, sequence and ack numbers.
// cmd: the run of commands the event causes (send data/ACK/NAK, deliver
//   slot, stop data timer, restart ack timer); every run ends with a status
//   beat that has last set and carries network_enable.
// One event is worked at a time by a microcode sequencer: the event beat is
// taken, then the control store steps run in turn and at most one command
// beat leaves per step. An undefined action runs only the status step, the
// other local events their own step and then the status step; a good data
// frame also runs a delivery step for each released slot and a retire step
// for each frame its ack retires. Command beats are registered: each shows
// on cmd from the output register that its step loads.
// evt.ready is high from the cycle the status beat is presented on cmd until
// the next event beat is taken.
// A stalled cmd holds its beat and freezes the sequencer on its next
// beat-emitting step; non-emitting and condition-skipped steps still run.
// Reset empties both windows, clears the arrival bitmap and physical-ready
// and allows NAKs; the block takes an event as soon as reset is released.
// ----------------------------------------------------------------------------
module selective_repeat_window_control import srwc_pkg::*; #(
    parameter int SEQ_MAX      = SEQ_MAX_DEF,
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    srwc_evt_if.sink   evt,
    srwc_cmd_if.source cmd
);

    ctrl_t    ctrl;
    dp_stat_t stat;
    logic     in_ready;

    assign evt.ready = in_ready;

    srwc_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt.valid),
        .in_ready (in_ready),
        .action   (evt.action),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    srwc_datapath #(
        .SEQ_MAX      (SEQ_MAX),
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .frame_good (evt.frame_good),
        .frame_kind (evt.frame_kind),
        .frame_seq  (evt.frame_seq),
        .peer_ack   (evt.peer_ack),
        .stat       (stat),
        .cmd        (cmd)
    );

endmodule

// File: rtl/srwc_checker.sv
// ----------------------------------------------------------------------------
// srwc_sva
// Port-level checks of the window control block, bound to the top level.
// ----------------------------------------------------------------------------
module srwc_sva import srwc_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    evt_valid,
    input logic                    evt_ready,
    input logic                    cmd_valid,
    input logic                    cmd_ready,
    input logic [CMD_W-1:0]        command,
    input logic [SEQ_FIELD_W-1:0]  seq_out,
    input logic [SEQ_FIELD_W-1:0]  ack_out,
    input logic [SLOT_FIELD_W-1:0] slot,
    input logic                    network_enable,
    input logic                    last
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(command) &&
        $stable(seq_out) && $stable(ack_out) && $stable(slot) &&
        $stable(network_enable) && $stable(last))
        else $error("stalled command beat changed");

    // exactly the status beat closes a run
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (last == (command == CMD_STATUS)))
        else $error("last flag does not match status command");

    a_ne: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (command != CMD_STATUS) |-> !network_enable)
        else $error("network enable outside status beat");

    // one event in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("event taken while a run is in progress");

    // ready returns only once the status beat is presented
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt_ready) |-> cmd_valid && last)
        else $error("event port reopened without a status beat");

endmodule

bind selective_repeat_window_control srwc_sva u_srwc_sva (
    .clk            (clk),
    .rst_n          (rst_n),
    .evt_valid      (evt.valid),
    .evt_ready      (evt.ready),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .command        (cmd.command),
    .seq_out        (cmd.seq_out),
    .ack_out        (cmd.ack_out),
    .slot           (cmd.slot),
    .network_enable (cmd.network_enable),
    .last           (cmd.last)
);

// File: verif/srwc_checker.sv
// ----------------------------------------------------------------------------
// srwc_checker
// Watches the event and command channels of the selective-repeat window
// control block, predicts the command run of every accepted event from its
// own copy of the window state, and compares each accepted command beat.
// ----------------------------------------------------------------------------
module srwc_checker import srwc_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    srwc_evt_if    evt,
    srwc_cmd_if    cmd,
    output int     fail_count,
    output int     pending,
    output int     beats_checked
);

    localparam int SLOTS = WINDOW_SLOTS_DEF;

    typedef logic [SEQ_FIELD_W-1:0]  seq_t;
    typedef logic [SLOT_FIELD_W-1:0] slot_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        seq_t             seq_out;
        seq_t             ack_out;
        slot_t            slot;
        logic             network_enable;
        logic             last;
    } cmd_beat_t;

    cmd_beat_t cmd_due[$];

    // Window state
    seq_t tx_base;
    seq_t tx_next;
    seq_t rx_base;
    seq_t rx_limit;
    int   unacked;
    logic nak_ok;
    logic phys_rdy;
    logic rx_marked [SLOTS];

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        beats_checked = 0;
    end

    function automatic logic seq_between(seq_t lo, seq_t x, seq_t hi);
        return ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
               ((x < hi) && (hi < lo));
    endfunction

    task automatic clear_windows();
        tx_base  = '0;
        tx_next  = '0;
        rx_base  = '0;
        rx_limit = seq_t'(SLOTS);
        unacked  = 0;
        nak_ok   = 1'b1;
        phys_rdy = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rx_marked[i] = 1'b0;
        end
        cmd_due.delete();
    endtask

    task automatic issue(logic [CMD_W-1:0] c, seq_t s, seq_t a, slot_t sl,
                         logic ne, logic lst);
        cmd_beat_t b;
        b.command        = c;
        b.seq_out        = s;
        b.ack_out        = a;
        b.slot           = sl;
        b.network_enable = ne;
        b.last           = lst;
        cmd_due.push_back(b);
    endtask

    // Any send drops physical-ready; a NAK also blocks further NAKs
    task automatic tx_frame(logic [CMD_W-1:0] c, seq_t s);
        seq_t piggy;
        piggy = rx_base - 1'b1;
        if (c == CMD_SEND_DATA)
        begin
            issue(CMD_SEND_DATA, s, piggy, slot_t'(s % SLOTS), 1'b0, 1'b0);
        end
        else
        begin
            issue(c, '0, piggy, '0, 1'b0, 1'b0);
        end
        if (c == CMD_SEND_NAK)
        begin
            nak_ok = 1'b0;
        end
        phys_rdy = 1'b0;
    endtask

    task automatic frame_arrived(logic good, logic [KIND_W-1:0] kind, seq_t seq,
                                 seq_t ack);
        seq_t want;
        logic delivered;
        delivered = 1'b0;
        if (!good)
        begin
            if (nak_ok)
            begin
                tx_frame(CMD_SEND_NAK, '0);
            end
            return;
        end
        if (kind == FK_DATA)
        begin
            if (seq != rx_base && nak_ok)
            begin
                tx_frame(CMD_SEND_NAK, '0);
            end
            else
            begin
                issue(CMD_RESTART_ACK, '0, '0, '0, 1'b0, 1'b0);
            end
            if (seq_between(rx_base, seq, rx_limit) && !rx_marked[seq % SLOTS])
            begin
                rx_marked[seq % SLOTS] = 1'b1;
                // release the in-order run starting at the receive base
                while (rx_marked[rx_base % SLOTS])
                begin
                    issue(CMD_DELIVER, '0, '0, slot_t'(rx_base % SLOTS), 1'b0, 1'b0);
                    nak_ok                 = 1'b1;
                    rx_marked[rx_base % SLOTS] = 1'b0;
                    rx_base                = rx_base + 1'b1;
                    rx_limit               = rx_limit + 1'b1;
                    delivered              = 1'b1;
                end
                if (delivered)
                begin
                    issue(CMD_RESTART_ACK, '0, '0, '0, 1'b0, 1'b0);
                end
            end
        end
        if (kind == FK_NAK)
        begin
            want = ack + 1'b1;
            if (seq_between(tx_base, want, tx_next))
            begin
                tx_frame(CMD_SEND_DATA, want);
            end
        end
        // cumulative ack rides on every good frame
        while (seq_between(tx_base, ack, tx_next))
        begin
            if (unacked > 0)
            begin
                unacked--;
            end
            issue(CMD_STOP_TIMER, '0, '0, slot_t'(tx_base % SLOTS), 1'b0, 1'b0);
            tx_base = tx_base + 1'b1;
        end
    endtask

    task automatic predict_event(logic [ACTION_W-1:0] act, logic good,
                                 logic [KIND_W-1:0] kind, seq_t seq, seq_t ack);
        case (act)
            ACT_PACKET:
            begin
                if (unacked < SLOTS)
                begin
                    unacked++;
                    tx_frame(CMD_SEND_DATA, tx_next);
                    tx_next = tx_next + 1'b1;
                end
            end
            ACT_PHYS_READY:   phys_rdy = 1'b1;
            ACT_FRAME:        frame_arrived(good, kind, seq, ack);
            ACT_DATA_TIMEOUT: tx_frame(CMD_SEND_DATA, tx_base);
            ACT_ACK_TIMEOUT:  tx_frame(CMD_SEND_ACK, '0);
            default:          ;
        endcase
        issue(CMD_STATUS, '0, '0, '0, (unacked < SLOTS) && phys_rdy, 1'b1);
    endtask

    task automatic check_beat();
        cmd_beat_t want;
        cmd_beat_t got;
        got.command        = cmd.command;
        got.seq_out        = cmd.seq_out;
        got.ack_out        = cmd.ack_out;
        got.slot           = cmd.slot;
        got.network_enable = cmd.network_enable;
        got.last           = cmd.last;
        beats_checked++;
        if (cmd_due.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected beat cmd=%0d seq=%0d ack=%0d slot=%0d ne=%0b last=%0b",
                     $time, got.command, got.seq_out, got.ack_out, got.slot,
                     got.network_enable, got.last);
            return;
        end
        want = cmd_due.pop_front();
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: expected cmd=%0d seq=%0d ack=%0d slot=%0d ne=%0b last=%0b",
                     $time, want.command, want.seq_out, want.ack_out, want.slot,
                     want.network_enable, want.last);
            $display("%0t: actual   cmd=%0d seq=%0d ack=%0d slot=%0d ne=%0b last=%0b",
                     $time, got.command, got.seq_out, got.ack_out, got.slot,
                     got.network_enable, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_windows();
        end
        else
        begin
            if (evt.valid && evt.ready)
            begin
                predict_event(evt.action, evt.frame_good, evt.frame_kind,
                              evt.frame_seq, evt.peer_ack);
            end
            if (cmd.valid && cmd.ready)
            begin
                check_beat();
            end
        end
        pending = cmd_due.size();
    end

endmodule

// File: verif/tb_selective_repeat_window_control.sv
// ----------------------------------------------------------------------------
// tb_selective_repeat_window_control
// Drives link events into the selective-repeat window control block: a
// directed opening, then receive bursts in shuffled, reversed and in-order
// sequence, transmit runs that fill the send window, acks, NAKs, timeouts
// and noise. The command side stalls on its own pattern, once for a long
// stretch. The checker beside the block judges every command beat.
// ----------------------------------------------------------------------------
module tb_selective_repeat_window_control;
    import srwc_pkg::*;

    localparam int N_RANDOM    = 260;
    localparam int HOLD_AT     = 130;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 60;

    localparam logic [ACTION_W-1:0] ACT_UNDEF_LO  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_MID = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNDEF_HI  = 3'd7;
    localparam logic [KIND_W-1:0]   FK_UNDEF      = 2'd3;

    typedef logic [SEQ_FIELD_W-1:0] seq_t;

    logic clk;
    logic rst_n;

    int   fail_count;
    int   pending;
    int   beats_checked;

    int   n_sent;
    int   n_bursts;
    int   n_runs;
    int   burst_left;
    bit   hold_req;
    bit   hold_done;

    // Peer view of the link, kept to shape well-formed frames
    seq_t tx_base;
    seq_t tx_next;
    seq_t rx_next;

    srwc_evt_if evt_ch ();
    srwc_cmd_if cmd_ch ();

    selective_repeat_window_control u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch.sink),
        .cmd   (cmd_ch.source)
    );

    srwc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt_ch),
        .cmd           (cmd_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d command beats outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // Command side: stall segments of random shape, one long hold-off
    initial
    begin
        int seg_kind;
        int seg_len;
        cmd_ch.ready = 1'b0;
        hold_done    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            seg_kind = $urandom_range(0, 3);
            seg_len  = $urandom_range(5, 60);
            for (int i = 0; i < seg_len; i++)
            begin
                @(posedge clk);
                if (hold_req && !hold_done)
                begin
                    hold_done = 1'b1;
                    cmd_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(posedge clk);
                    continue;
                end
                case (seg_kind)
                    0:       cmd_ch.ready <= 1'b1;
                    1:       cmd_ch.ready <= 1'($urandom_range(0, 1));
                    2:       cmd_ch.ready <= (i % 4 == 0);
                    default: cmd_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic seq_t in_flight();
        return tx_next - tx_base;
    endfunction

    // Mostly acks that retire nothing or part of the window, sometimes any value
    function automatic seq_t pick_ack();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 || (r < 8 && in_flight() == 0))
        begin
            return tx_base - 1'b1;
        end
        if (r < 8)
        begin
            return tx_base + seq_t'($urandom_range(0, in_flight() - 1));
        end
        return seq_t'($urandom_range(0, 31));
    endfunction

    task automatic send_event(logic [ACTION_W-1:0] act, logic good,
                              logic [KIND_W-1:0] kind, seq_t seq, seq_t ack);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                evt_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        evt_ch.valid      <= 1'b1;
        evt_ch.action     <= act;
        evt_ch.frame_good <= good;
        evt_ch.frame_kind <= kind;
        evt_ch.frame_seq  <= seq;
        evt_ch.peer_ack   <= ack;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        // track the send window as the peer sees it
        if (act == ACT_PACKET && in_flight() < WINDOW_SLOTS_DEF)
        begin
            tx_next = tx_next + 1'b1;
        end
        if (act == ACT_FRAME && good && seq_t'(ack - tx_base) < in_flight())
        begin
            tx_base = ack + 1'b1;
        end
        n_sent++;
        if (n_sent == HOLD_AT)
        begin
            hold_req = 1'b1;
        end
    endtask

    task automatic drive_frame_evt(logic good, logic [KIND_W-1:0] kind, seq_t seq,
                                   seq_t ack);
        send_event(ACT_FRAME, good, kind, seq, ack);
    endtask

    task automatic send_local(logic [ACTION_W-1:0] act);
        send_event(act, 1'($urandom_range(0, 1)), KIND_W'($urandom_range(0, 3)),
                   seq_t'($urandom_range(0, 31)), seq_t'($urandom_range(0, 31)));
    endtask

    task automatic send_noise();
        send_local(ACTION_W'($urandom_range(0, 7)));
    endtask

    initial
    begin
        seq_t order [16];
        seq_t tmp;
        int   mode;
        int   j;
        int   k;
        int   n_directed;

        rst_n             = 1'b0;
        evt_ch.valid      = 1'b0;
        evt_ch.action     = ACT_PACKET;
        evt_ch.frame_good = 1'b0;
        evt_ch.frame_kind = FK_DATA;
        evt_ch.frame_seq  = '0;
        evt_ch.peer_ack   = '0;
        n_sent     = 0;
        n_bursts   = 0;
        n_runs     = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        tx_base    = '0;
        tx_next    = '0;
        rx_next    = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening
        send_local(ACT_UNDEF_HI);
        send_local(ACT_UNDEF_LO);
        send_local(ACT_UNDEF_MID);
        send_local(ACT_DATA_TIMEOUT);          // resend with nothing outstanding
        send_local(ACT_ACK_TIMEOUT);
        send_local(ACT_PHYS_READY);
        send_local(ACT_PACKET);
        send_local(ACT_PACKET);
        send_local(ACT_PACKET);
        drive_frame_evt(1'b0, FK_DATA, 5'd31, 5'd31);  // bad frame: NAK
        drive_frame_evt(1'b0, FK_NAK, 5'd0, 5'd0);     // bad frame: NAK blocked
        drive_frame_evt(1'b1, FK_DATA, 5'd0, 5'd31);   // in order, delivers at once
        drive_frame_evt(1'b1, FK_DATA, 5'd3, 5'd31);   // gap ahead: NAK, hold slot
        drive_frame_evt(1'b1, FK_DATA, 5'd3, 5'd31);   // duplicate
        drive_frame_evt(1'b1, FK_DATA, 5'd20, 5'd31);  // outside receive window
        drive_frame_evt(1'b1, FK_DATA, 5'd2, 5'd31);
        drive_frame_evt(1'b1, FK_DATA, 5'd1, 5'd31);   // releases a run of three
        drive_frame_evt(1'b1, FK_NAK, 5'd31, 5'd0);    // resend 1, retire 0
        drive_frame_evt(1'b1, FK_UNDEF, 5'd0, 5'd2);   // odd kind acts as ack
        drive_frame_evt(1'b1, FK_ACK, 5'd31, 5'd31);
        send_local(ACT_DATA_TIMEOUT);
        send_local(ACT_PHYS_READY);
        n_directed = n_sent;
        rx_next    = 5'd4;

        while (n_sent < n_directed + N_RANDOM)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // one full receive window: shuffled, reversed or in order
                    n_bursts++;
                    mode = $urandom_range(0, 2);
                    for (int i = 0; i < 16; i++)
                    begin
                        order[i] = (mode == 1) ? rx_next + seq_t'(15 - i) : rx_next + seq_t'(i);
                    end
                    if (mode == 0)
                    begin
                        for (int i = 15; i > 0; i--)
                        begin
                            j        = $urandom_range(0, i);
                            tmp      = order[i];
                            order[i] = order[j];
                            order[j] = tmp;
                        end
                    end
                    for (int i = 0; i < 16; i++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            send_noise();
                        end
                        drive_frame_evt(1'b1, FK_DATA, order[i], pick_ack());
                    end
                    rx_next = rx_next + 5'd16;
                end
                3, 4, 5:
                begin
                    // fill the send window, then ack or NAK part of it
                    n_runs++;
                    k = $urandom_range(1, 18);
                    for (int i = 0; i < k; i++)
                    begin
                        if ($urandom_range(0, 1) == 1)
                        begin
                            send_local(ACT_PHYS_READY);
                        end
                        send_local(ACT_PACKET);
                    end
                    k = $urandom_range(0, 4);
                    for (int i = 0; i < k; i++)
                    begin
                        drive_frame_evt(1'b1, ($urandom_range(0, 1) == 1) ? FK_ACK : FK_NAK,
                                        seq_t'($urandom_range(0, 31)), pick_ack());
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        send_local(ACT_DATA_TIMEOUT);
                    end
                end
                6:
                begin
                    send_local(($urandom_range(0, 1) == 1) ? ACT_DATA_TIMEOUT : ACT_ACK_TIMEOUT);
                end
                7:
                begin
                    if (in_flight() > 0)
                    begin
                        drive_frame_evt(1'b1, FK_NAK, seq_t'($urandom_range(0, 31)),
                            tx_base + seq_t'($urandom_range(0, in_flight() - 1)) - 1'b1);
                    end
                    else
                    begin
                        send_local(ACT_PHYS_READY);
                    end
                end
                8:
                begin
                    drive_frame_evt(1'b0, KIND_W'($urandom_range(0, 3)),
                                    seq_t'($urandom_range(0, 31)), seq_t'($urandom_range(0, 31)));
                end
                default:
                begin
                    send_noise();
                end
            endcase
        end

        evt_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);

        $display("Drove %0d events: %0d receive window bursts, %0d transmit runs, one long stall",
                 n_sent, n_bursts, n_runs);
        $display("Checked %0d command beats, %0d mismatches", beats_checked, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/srwc_pkg.sv
rtl/srwc_if.sv
rtl/srwc_useq.sv
rtl/srwc_datapath.sv
rtl/selective_repeat_window_control.sv
rtl/srwc_checker.sv
verif/srwc_checker.sv
verif/tb_selective_repeat_window_control.sv
